### sv/fba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Shared payload types, operation and status codes, and sizing constants for
// the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

	// Sizing defaults and fixed field widths.
	localparam int FRAME_COUNT_DEF   = 4096;
	localparam int FRAME_W           = 12;
	localparam int FRAME_FIELD_LIMIT = 4096;
	localparam int WORD_W            = 32;
	localparam int BIT_IDX_W         = 5;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Status codes.
	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_NOP  = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	// Request payload.
	typedef struct packed {
		logic               operation;
		logic [FRAME_W-1:0] page_frame;
		logic               kernel_page;
		logic               writable_page;
	} fba_req_t;

	// Response payload.
	typedef struct packed {
		logic [1:0]         status;
		logic [FRAME_W-1:0] new_frame;
		logic               present_bit;
		logic               write_bit;
		logic               user_bit;
	} fba_rsp_t;

	// Control for the shared word unit.
	typedef struct packed {
		logic                 set_n_clr;
		logic [BIT_IDX_W-1:0] bit_idx;
		logic                 last_word;
	} fba_unit_ctl_t;

	// Status from the shared word unit.
	typedef struct packed {
		logic                 full;
		logic [BIT_IDX_W-1:0] pick;
	} fba_unit_sts_t;

endpackage

### sv/frame_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator core
// Page frame allocator over a used-bitmap held in a word memory, with a
// small sequencer driving one shared word unit.
// ----------------------------------------------------------------------------
// One request is handled at a time and the block is not ready while it works.
// An allocate for a page with no frame scans the bitmap one word per cycle
// through the single memory read port, from word 0 up to the first word with
// a free frame; the default 4096 frames give 128 words (words = frames/32
// rounded up, capped at 4096 frames). A free reads the frame's word and
// clears its bit in the S_FREE state, and a request with nothing to do
// returns its result on the cycle after the transfer. A new request is taken
// only when the result register is empty or being emptied. The bitmap is all
// free after reset with no clearing pass.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core
	import fba_pkg::*;
#(
	parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  fba_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output fba_rsp_t rsp
);

	localparam int SCAN_LIMIT = (FRAME_COUNT < FRAME_FIELD_LIMIT) ? FRAME_COUNT :
		FRAME_FIELD_LIMIT;
	localparam int MEM_WORDS  = (SCAN_LIMIT + WORD_W - 1) / WORD_W;
	localparam int AW         = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int LAST_BITS  = SCAN_LIMIT - WORD_W * (MEM_WORDS - 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FREE = 3'b100
	} state_t;

	state_t            state_q, state_d;
	fba_req_t          item_q;
	logic [AW-1:0]     chk_q, chk_d;
	fba_rsp_t          rsp_q, rsp_d;
	logic              rsp_valid_q;
	logic              rsp_load;
	logic              accept;
	logic [AW-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     free_addr;
	logic [WORD_W-1:0] new_word;
	fba_unit_ctl_t     unit_ctl;
	fba_unit_sts_t     unit_sts;
	logic              in_range;

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign free_addr = item_q.page_frame[AW+BIT_IDX_W-1:BIT_IDX_W];
	assign in_range  = {20'd0, req.page_frame} < 32'(FRAME_COUNT);

	// Read address: first word on an allocate, the frame's word on a free,
	// and the next word while scanning.
	always_comb begin
		case (state_q)
			S_SCAN: rd_addr = chk_q + AW'(1);
			default: begin
				if (req.operation == OP_FREE) begin
					rd_addr = req.page_frame[AW+BIT_IDX_W-1:BIT_IDX_W];
				end else begin
					rd_addr = '0;
				end
			end
		endcase
	end

	// Shared word unit control.
	assign unit_ctl.set_n_clr = (state_q == S_SCAN);
	assign unit_ctl.bit_idx   = item_q.page_frame[BIT_IDX_W-1:0];
	assign unit_ctl.last_word = (chk_q == LAST_ADDR);

	assign wr_addr = (state_q == S_FREE) ? free_addr : chk_q;

	// Sequencer and result formation.
	always_comb begin
		state_d  = state_q;
		chk_d    = chk_q;
		rsp_d    = rsp_q;
		rsp_load = 1'b0;
		wr_en    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rsp_d = '{status: STATUS_NOP, new_frame: '0, present_bit: 1'b0,
						write_bit: 1'b0, user_bit: 1'b0};
					chk_d = '0;
					if (req.operation == OP_ALLOC) begin
						if (req.page_frame != '0) begin
							rsp_d.new_frame = req.page_frame;
							rsp_load        = 1'b1;
						end else begin
							state_d = S_SCAN;
						end
					end else begin
						if (req.page_frame == '0) begin
							rsp_load = 1'b1;
						end else if (!in_range) begin
							rsp_d.status = STATUS_DONE;
							rsp_load     = 1'b1;
						end else begin
							state_d = S_FREE;
						end
					end
				end
			end
			S_SCAN: begin
				if (!unit_sts.full) begin
					wr_en    = 1'b1;
					rsp_load = 1'b1;
					rsp_d    = '{status: STATUS_DONE,
						new_frame: FRAME_W'({chk_q, unit_sts.pick}),
						present_bit: 1'b1, write_bit: item_q.writable_page,
						user_bit: ~item_q.kernel_page};
					state_d  = S_IDLE;
				end else if (chk_q == LAST_ADDR) begin
					rsp_load = 1'b1;
					rsp_d    = '{status: STATUS_FULL, new_frame: '0, present_bit: 1'b0,
						write_bit: 1'b0, user_bit: 1'b0};
					state_d  = S_IDLE;
				end else begin
					chk_d = chk_q + AW'(1);
				end
			end
			S_FREE: begin
				wr_en    = 1'b1;
				rsp_load = 1'b1;
				rsp_d    = '{status: STATUS_DONE, new_frame: '0, present_bit: 1'b0,
					write_bit: 1'b0, user_bit: 1'b0};
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chk_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_q   <= chk_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		rsp_q <= rsp_d;
	end

	fba_bitmap_mem #(
		.DEPTH (MEM_WORDS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (new_word)
	);

	fba_word_unit #(
		.LAST_BITS (LAST_BITS)
	) u_unit (
		.word     (rd_data),
		.ctl      (unit_ctl),
		.sts      (unit_sts),
		.new_word (new_word)
	);

endmodule

### sv/fba_bitmap_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap memory
// One word per 32 frames, one write and one registered read per cycle. A
// word that has never been written reads as zero through its valid bit.
// ----------------------------------------------------------------------------
module fba_bitmap_mem
	import fba_pkg::*;
#(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [AW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [WORD_W-1:0] rd_word_q;
	logic              rd_valid_q;

	// Storage array and registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_word_q <= mem[rd_addr];
	end

	// Valid bits clear at reset, so the whole bitmap starts free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : '0;

endmodule

### sv/fba_word_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap word unit
// Shared unit that tests one bitmap word for a free frame, picks the lowest
// free bit, and forms the updated word for a set or a clear.
// ----------------------------------------------------------------------------
module fba_word_unit
	import fba_pkg::*;
#(
	parameter int LAST_BITS = 32
) (
	input  logic [WORD_W-1:0] word,
	input  fba_unit_ctl_t     ctl,
	output fba_unit_sts_t     sts,
	output logic [WORD_W-1:0] new_word
);

	// Bits of the last word that lie beyond the scan range count as used.
	localparam logic [WORD_W-1:0] HIGH_MASK = (LAST_BITS >= WORD_W) ? '0 :
		~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

	logic [WORD_W-1:0]    eff_word;
	logic [BIT_IDX_W-1:0] pick;
	logic [BIT_IDX_W-1:0] idx;
	logic [WORD_W-1:0]    onehot;

	assign eff_word = ctl.last_word ? (word | HIGH_MASK) : word;

	// Lowest clear bit of the effective word.
	always_comb begin
		pick = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!eff_word[i]) begin
				pick = BIT_IDX_W'(i);
			end
		end
	end

	assign sts.full = &eff_word;
	assign sts.pick = pick;

	// Set the picked bit on allocation, clear the given bit on free.
	assign idx      = ctl.set_n_clr ? pick : ctl.bit_idx;
	assign onehot   = WORD_W'(1) << idx;
	assign new_word = ctl.set_n_clr ? (word | onehot) : (word & ~onehot);

endmodule
